FILE: design/mpct_pkg.sv
`timescale 1ns / 1ps
// Package for the mouse packet cursor tracker.
// Holds field widths, reset values, status bit positions, register indexes and state codes.
package mpct_pkg;

  localparam int RX_BITS            = 8;
  localparam int CFG_BITS           = 12;
  localparam int OUT_BITS           = 12;
  localparam int CFG_INDEX_BITS     = 2;
  localparam int COORD_BITS_DEFAULT = 12;

  localparam int MAX_COLUMN_RESET = 799;
  localparam int MAX_ROW_RESET    = 599;
  localparam int COLUMN_RESET     = 400;
  localparam int ROW_RESET        = 300;

  localparam int STATUS_LEFT   = 0;
  localparam int STATUS_X_SIGN = 4;
  localparam int STATUS_Y_SIGN = 5;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MAX_COLUMN = 2'd0,
    REG_MAX_ROW    = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    POS_STATUS = 3'b001,
    POS_MOVE_X = 3'b010,
    POS_MOVE_Y = 3'b100
  } byte_pos_t;

endpackage

FILE: design/mpct_rx_if.sv
`timescale 1ns / 1ps
// Byte channel from the mouse link receiver: valid, ready and one received byte.
// Depends on mpct_pkg.
interface mpct_rx_if import mpct_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RX_BITS-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: design/mpct_pos_if.sv
`timescale 1ns / 1ps
// Result channel: cursor position and left button after each completed packet.
// Depends on mpct_pkg.
interface mpct_pos_if import mpct_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] cursor_column;
  logic [OUT_BITS-1:0] cursor_row;
  logic                left_pressed;

  modport source (output valid, output cursor_column, output cursor_row,
                  output left_pressed, input ready);
  modport sink   (input valid, input cursor_column, input cursor_row,
                  input left_pressed, output ready);
endinterface

FILE: design/mpct_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel: valid, ready, register index and write data.
// Depends on mpct_pkg.
interface mpct_cfg_if import mpct_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_BITS-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/mouse_packet_cursor_tracker_unit.sv
`timescale 1ns / 1ps
// Mouse packet cursor tracker top level.
// Depends on mpct_pkg, mpct_rx_if, mpct_pos_if and mpct_cfg_if.

// Takes mouse bytes in strict turn as three-byte packets (status, X move, Y move) and, on
// the third byte, moves the cursor by X and against Y, clamps each axis to 0 through the
// max_column / max_row registers and emits column, row and left button. There is no
// packet resync: bytes are counted from reset. One byte is taken every cycle; a result
// appears in the output register the cycle after its third byte and waits there until
// taken, while status and X bytes of the next packet keep flowing. Only a third byte
// stalls, and only while the previous result is still untaken. The add and clamp on each
// axis is the single combinational path from held and incoming bytes to position registers.
// Configuration writes are taken in any cycle; a lowered maximum clamps on the next packet.
module mouse_packet_cursor_tracker_unit
  import mpct_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  mpct_rx_if.sink    rx,
  mpct_pos_if.source pos,
  mpct_cfg_if.sink   cfg
);

  localparam int SUM_BITS = COORD_BITS + 2;

  localparam logic [COORD_BITS-1:0] MAX_COLUMN_INIT = COORD_BITS'(MAX_COLUMN_RESET);
  localparam logic [COORD_BITS-1:0] MAX_ROW_INIT    = COORD_BITS'(MAX_ROW_RESET);
  localparam logic [COORD_BITS-1:0] COLUMN_INIT     = COORD_BITS'(COLUMN_RESET);
  localparam logic [COORD_BITS-1:0] ROW_INIT        = COORD_BITS'(ROW_RESET);

  logic [COORD_BITS-1:0] max_column;
  logic [COORD_BITS-1:0] max_row;
  byte_pos_t             byte_position;
  logic [RX_BITS-1:0]    held_status;
  logic [RX_BITS-1:0]    held_move_x;
  logic [COORD_BITS-1:0] column_pos;
  logic [COORD_BITS-1:0] row_pos;
  logic                  button_left;
  logic                  out_valid;

  logic                  rx_take;
  logic                  packet_done;
  logic signed [8:0]     move_x;
  logic signed [8:0]     move_y;
  logic signed [SUM_BITS-1:0] column_sum;
  logic signed [SUM_BITS-1:0] row_sum;
  logic [COORD_BITS-1:0] column_next;
  logic [COORD_BITS-1:0] row_next;

  assign rx.ready    = (byte_position != POS_MOVE_Y) || !out_valid || pos.ready;
  assign rx_take     = rx.valid && rx.ready;
  assign packet_done = rx_take && (byte_position == POS_MOVE_Y);
  assign cfg.ready   = 1'b1;

  assign move_x = $signed({held_status[STATUS_X_SIGN], held_move_x});
  assign move_y = $signed({held_status[STATUS_Y_SIGN], rx.rx_byte});

  always_comb begin
    column_sum = $signed({2'b00, column_pos}) + SUM_BITS'(move_x);
    row_sum    = $signed({2'b00, row_pos}) - SUM_BITS'(move_y);

    if (column_sum < 0) begin
      column_next = '0;
    end else if (column_sum > $signed({2'b00, max_column})) begin
      column_next = max_column;
    end else begin
      column_next = column_sum[COORD_BITS-1:0];
    end

    if (row_sum < 0) begin
      row_next = '0;
    end else if (row_sum > $signed({2'b00, max_row})) begin
      row_next = max_row;
    end else begin
      row_next = row_sum[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_column <= MAX_COLUMN_INIT;
      max_row    <= MAX_ROW_INIT;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_MAX_COLUMN: max_column <= COORD_BITS'(cfg.data);
        REG_MAX_ROW:    max_row    <= COORD_BITS'(cfg.data);
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_STATUS;
      held_status   <= '0;
      held_move_x   <= '0;
      column_pos    <= COLUMN_INIT;
      row_pos       <= ROW_INIT;
      button_left   <= 1'b0;
    end else if (rx_take) begin
      case (byte_position)
        POS_MOVE_X: begin
          held_move_x   <= rx.rx_byte;
          byte_position <= POS_MOVE_Y;
        end
        POS_MOVE_Y: begin
          column_pos    <= column_next;
          row_pos       <= row_next;
          button_left   <= held_status[STATUS_LEFT];
          byte_position <= POS_STATUS;
        end
        default: begin
          held_status   <= rx.rx_byte;
          byte_position <= POS_MOVE_X;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (packet_done) begin
      out_valid <= 1'b1;
    end else if (pos.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (packet_done) begin
      pos.cursor_column <= OUT_BITS'(column_next);
      pos.cursor_row    <= OUT_BITS'(row_next);
    end
  end

  assign pos.valid        = out_valid;
  assign pos.left_pressed = button_left;

endmodule
